[hdl/escape_sequence_to_utf8_unit_defines.svh]
// ---------------------------------------------------------------------------
// escape_sequence_to_utf8_unit_defines
// Assertion macros shared by the escape decoder queue and serializer.
// ---------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_TO_UTF8_UNIT_DEFINES_SVH
`define ESCAPE_SEQUENCE_TO_UTF8_UNIT_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define ESU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ESU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/esu_pkg.sv]
// ---------------------------------------------------------------------------
// esu_pkg
// Types and constants shared by the escape sequence to UTF-8 decoder.
// ---------------------------------------------------------------------------
package esu_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MAX_ITEMS  = 4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_LETTER = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ESC  = 4'b0010,
    MODE_HEX  = 4'b0100,
    MODE_OCT  = 4'b1000
  } mode_t;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic [2:0] err;
  } item_t;

  // all result items caused by one input item; last is index of final item
  typedef struct packed {
    logic [1:0]            last;
    item_t [MAX_ITEMS-1:0] items;
  } cmd_t;

endpackage

[hdl/esu_front.sv]
// ---------------------------------------------------------------------------
// esu_front
// Escape parser: tracks the escape state and turns each input item into a
// list of 0..4 result items (UTF-8 bytes and error marks).
// ---------------------------------------------------------------------------
module esu_front import esu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,       // input item accepted this cycle
  input  logic [7:0] data_byte,
  input  logic       end_mark,
  output logic       cmd_valid, // item produced at least one result
  output cmd_t       cmd
);

  mode_t       mode_r, mode_nxt;
  logic [3:0]  digits_r, digits_nxt;
  logic [1:0]  octal_r, octal_nxt;
  logic [31:0] code_r, code_nxt;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    // bit 4 set when b is a hex digit
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
    if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      return {1'b1, b[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [8:0] letter_code(input logic [7:0] b);
    case (b)
      8'h61:   letter_code = {1'b1, 8'h07};
      8'h62:   letter_code = {1'b1, 8'h08};
      8'h66:   letter_code = {1'b1, 8'h0c};
      8'h6e:   letter_code = {1'b1, 8'h0a};
      8'h72:   letter_code = {1'b1, 8'h0d};
      8'h74:   letter_code = {1'b1, 8'h09};
      8'h76:   letter_code = {1'b1, 8'h0b};
      8'h22:   letter_code = {1'b1, 8'h22};
      8'h5c:   letter_code = {1'b1, 8'h5c};
      default: letter_code = 9'd0;
    endcase
  endfunction

  logic        emit_en, perr_en, pass_en, trunc_en;
  logic [2:0]  perr_code;
  logic [31:0] emit_cp;
  logic [4:0]  hd;
  logic [8:0]  lc;
  logic        is_oct;

  // parse
  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    octal_nxt  = octal_r;
    code_nxt   = code_r;
    emit_en    = 1'b0;
    emit_cp    = code_r;
    perr_en    = 1'b0;
    perr_code  = ERR_NONE;
    pass_en    = 1'b0;
    trunc_en   = 1'b0;
    hd         = hex_digit(data_byte);
    lc         = letter_code(data_byte);
    is_oct     = (data_byte >= 8'h30) && (data_byte <= 8'h37);

    case (mode_r)
      MODE_ESC: begin
        mode_nxt   = MODE_IDLE;
        digits_nxt = 4'd0;
        octal_nxt  = 2'd0;
        code_nxt   = 32'd0;
        if (lc[8]) begin
          emit_en = 1'b1;
          emit_cp = {24'd0, lc[7:0]};
        end else if (data_byte == 8'h78 || data_byte == 8'h75 || data_byte == 8'h55) begin
          mode_nxt   = MODE_HEX;
          digits_nxt = (data_byte == 8'h78) ? 4'd2 : (data_byte == 8'h75) ? 4'd4 : 4'd8;
        end else if (is_oct) begin
          mode_nxt  = MODE_OCT;
          octal_nxt = 2'd1;
          code_nxt  = {29'd0, data_byte[2:0]};
        end else begin
          perr_en   = 1'b1;
          perr_code = ERR_BAD_LETTER;
        end
      end
      MODE_HEX: begin
        if (!hd[4]) begin
          mode_nxt   = MODE_IDLE;
          digits_nxt = 4'd0;
          code_nxt   = 32'd0;
          perr_en    = 1'b1;
          perr_code  = ERR_BAD_HEX;
        end else begin
          code_nxt   = {code_r[27:0], hd[3:0]};
          digits_nxt = digits_r - 4'd1;
          if (digits_nxt == 4'd0) begin
            emit_en  = 1'b1;
            emit_cp  = code_nxt;
            mode_nxt = MODE_IDLE;
            code_nxt = 32'd0;
          end
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          code_nxt  = {code_r[28:0], data_byte[2:0]};
          octal_nxt = octal_r + 2'd1;
          if (octal_nxt == 2'd3) begin
            emit_en   = 1'b1;
            emit_cp   = code_nxt;
            mode_nxt  = MODE_IDLE;
            octal_nxt = 2'd0;
            code_nxt  = 32'd0;
          end
        end else begin
          // escape ends here; the byte is then handled from idle
          emit_en   = 1'b1;
          emit_cp   = code_r;
          octal_nxt = 2'd0;
          code_nxt  = 32'd0;
          if (data_byte == CH_BACKSLASH) mode_nxt = MODE_ESC;
          else begin
            mode_nxt = MODE_IDLE;
            pass_en  = 1'b1;
          end
        end
      end
      default: begin
        digits_nxt = 4'd0;
        octal_nxt  = 2'd0;
        code_nxt   = 32'd0;
        if (data_byte == CH_BACKSLASH) mode_nxt = MODE_ESC;
        else begin
          mode_nxt = MODE_IDLE;
          pass_en  = 1'b1;
        end
      end
    endcase

    // end mark flushes a pending octal escape, flags anything else
    if (end_mark) begin
      if (mode_nxt == MODE_OCT) begin
        emit_en = 1'b1;
        emit_cp = code_nxt;
      end else if (mode_nxt != MODE_IDLE) begin
        trunc_en = 1'b1;
      end
      mode_nxt   = MODE_IDLE;
      digits_nxt = 4'd0;
      octal_nxt  = 2'd0;
      code_nxt   = 32'd0;
    end
  end

  // UTF-8 encode of the emitted code point
  logic [20:0] cp21;
  logic        cp_bad;
  item_t [3:0] enc;
  logic [2:0]  enc_n;

  always_comb begin
    cp_bad = (emit_cp >= 32'h0000_d800 && emit_cp <= 32'h0000_dfff) ||
             (emit_cp > 32'h0010_ffff);
    cp21   = cp_bad ? 21'h00fffd : emit_cp[20:0];
    enc    = '0;
    if (emit_cp[31]) begin
      enc[0] = '{data: 8'h00, has: 1'b0, err: ERR_OVERFLOW};
      enc_n  = 3'd1;
    end else if (cp21 < 21'h80) begin
      enc[0] = '{data: {1'b0, cp21[6:0]}, has: 1'b1, err: ERR_NONE};
      enc_n  = 3'd1;
    end else if (cp21 < 21'h800) begin
      enc[0] = '{data: {3'b110, cp21[10:6]}, has: 1'b1, err: ERR_NONE};
      enc[1] = '{data: {2'b10, cp21[5:0]}, has: 1'b1, err: ERR_NONE};
      enc_n  = 3'd2;
    end else if (cp21 < 21'h10000) begin
      enc[0] = '{data: {4'b1110, cp21[15:12]}, has: 1'b1, err: ERR_NONE};
      enc[1] = '{data: {2'b10, cp21[11:6]}, has: 1'b1, err: ERR_NONE};
      enc[2] = '{data: {2'b10, cp21[5:0]}, has: 1'b1, err: ERR_NONE};
      enc_n  = 3'd3;
    end else begin
      enc[0] = '{data: {5'b11110, cp21[20:18]}, has: 1'b1, err: ERR_NONE};
      enc[1] = '{data: {2'b10, cp21[17:12]}, has: 1'b1, err: ERR_NONE};
      enc[2] = '{data: {2'b10, cp21[11:6]}, has: 1'b1, err: ERR_NONE};
      enc[3] = '{data: {2'b10, cp21[5:0]}, has: 1'b1, err: ERR_NONE};
      enc_n  = 3'd4;
    end
  end

  // pack results in order: code point or error, passed byte, truncation
  logic [2:0] n;
  always_comb begin
    cmd = '0;
    n   = 3'd0;
    if (emit_en) begin
      cmd.items = enc;
      n         = enc_n;
    end else if (perr_en) begin
      cmd.items[0] = '{data: 8'h00, has: 1'b0, err: perr_code};
      n            = 3'd1;
    end
    if (pass_en) begin
      cmd.items[n[1:0]] = '{data: data_byte, has: 1'b1, err: ERR_NONE};
      n                 = n + 3'd1;
    end
    if (trunc_en) begin
      cmd.items[n[1:0]] = '{data: 8'h00, has: 1'b0, err: ERR_TRUNCATED};
      n                 = n + 3'd1;
    end
    cmd.last  = n[1:0] - 2'd1;
    cmd_valid = acc && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      digits_r <= 4'd0;
      octal_r  <= 2'd0;
      code_r   <= 32'd0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      octal_r  <= octal_nxt;
      code_r   <= code_nxt;
    end
  end

endmodule

[hdl/esu_fifo.sv]
// ---------------------------------------------------------------------------
// esu_fifo
// Short queue of decoded result lists between parser and serializer.
// ---------------------------------------------------------------------------
`include "escape_sequence_to_utf8_unit_defines.svh"

module esu_fifo import esu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `ESU_ASSERT_ALWAYS(a_no_overflow, !(push && full && !pop), "push into full queue")
  `ESU_ASSERT_ALWAYS(a_no_underflow, !(pop && !head_valid), "pop from empty queue")

endmodule

[hdl/esu_back.sv]
// ---------------------------------------------------------------------------
// esu_back
// Serializer: walks the head result list one item per cycle into the
// output register while out_tready is high or the register is empty.
// ---------------------------------------------------------------------------
`include "escape_sequence_to_utf8_unit_defines.svh"

module esu_back import esu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic [1:0] idx_r;
  logic       valid_r;
  item_t      item_r;
  logic       last_r;
  logic       load, at_last;

  assign load    = head_valid && (!valid_r || out_tready);
  assign at_last = (idx_r == head_cmd.last);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= head_cmd.items[idx_r];
      last_r <= at_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, item_r.err, item_r.data};
  assign out_tuser  = item_r.has;
  assign out_tlast  = last_r;

  `ESU_ASSERT_ALWAYS(a_idx_in_list, !head_valid || (idx_r <= head_cmd.last),
                     "item index past end of list")
  `ESU_ASSERT_ALWAYS(a_error_no_byte, !(valid_r && !item_r.has) || (item_r.data == 8'h00),
                     "error item carries a byte")
  `ESU_ASSERT_NEXT(a_stall_hold, valid_r && !out_tready, valid_r && $stable(item_r),
                   "stalled output item changed")

endmodule

[hdl/escape_sequence_to_utf8_unit.sv]
// ---------------------------------------------------------------------------
// escape_sequence_to_utf8_unit
// Decodes C string literal escapes in a byte stream into UTF-8 bytes.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                             | tuser    | tlast
//  in_     | in  | [7:0] data_byte                   | -        | end_mark
//  out_    | out | [7:0] out_byte, [10:8] error_code | has_byte | last_of_run
//
// One input item per cycle is accepted while the 4-entry result queue has room.
// Each input item yields 0..4 output items, sent one per cycle while out_tready
// is high from the queue head, so output rate bounds throughput when escapes
// expand to multi-byte runs. Results pass queue write, then output register.
// Reset clears parser state, queue and output register; no clearing pass.
// out_tready low holds the output item; in_tready drops only when the queue is full.
// ---------------------------------------------------------------------------
module escape_sequence_to_utf8_unit import esu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] error_code
  output logic        out_tuser,  // [0] has_byte
  output logic        out_tlast
);

  logic acc, cmd_valid, full, pop, head_valid;
  cmd_t cmd, head_cmd;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  esu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_tdata),
    .end_mark  (in_tlast),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  esu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  esu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/sv/escape_sequence_to_utf8_unit_tb.sv]
// ----------------------------------------------------------------------------
// escape_sequence_to_utf8_unit_tb
// Self-checking bench for the string-literal escape decoder. A directed table
// hits the byte extremes, octal and hex escapes and every error path. Random
// escape sequences follow under several idle/stall mixes and one long output
// hold-off. Each output item is checked against the in-bench model or a typed row.
// ----------------------------------------------------------------------------
module escape_sequence_to_utf8_unit_tb import esu_pkg::*; ();

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic [2:0] err;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eom;
  } stim_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eom;
    logic       typed;
    res_t       want;
  } row_t;

  localparam res_t NONE_RES = '0;
  localparam logic [7:0] ESC_LETTERS [9] = '{"a", "b", "f", "n", "r", "t", "v", 8'h22,
                                              CH_BACKSLASH};

  // typed rows carry their one result; the rest go through the decoder model
  localparam row_t DIR_ROWS [27] = '{
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, ERR_NONE, 1'b1}},
    '{8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, ERR_NONE, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, NONE_RES},
    '{"4", 1'b0, 1'b0, NONE_RES},
    '{CH_BACKSLASH, 1'b0, 1'b0, NONE_RES},    // ends octal, opens new escape
    '{"q", 1'b0, 1'b1, '{8'h00, 1'b0, ERR_BAD_LETTER, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, NONE_RES},
    '{"x", 1'b0, 1'b0, NONE_RES},
    '{"G", 1'b0, 1'b1, '{8'h00, 1'b0, ERR_BAD_HEX, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, NONE_RES},
    '{"7", 1'b0, 1'b0, NONE_RES},
    '{"7", 1'b0, 1'b0, NONE_RES},
    '{"7", 1'b0, 1'b0, NONE_RES},
    '{CH_BACKSLASH, 1'b0, 1'b0, NONE_RES},
    '{"1", 1'b1, 1'b0, NONE_RES},             // end mark flushes octal
    '{CH_BACKSLASH, 1'b0, 1'b0, NONE_RES},
    '{"u", 1'b1, 1'b1, '{8'h00, 1'b0, ERR_TRUNCATED, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, NONE_RES},
    '{"U", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b0, NONE_RES},
    '{"F", 1'b0, 1'b1, '{8'h00, 1'b0, ERR_OVERFLOW, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // [7:0] out_byte, [10:8] error_code
  logic        out_tuser;   // [0] has_byte
  logic        out_tlast;

  // decoder model state
  mode_t       esc_mode;
  logic [3:0]  hex_left;
  logic [1:0]  oct_digits;
  logic [31:0] code_acc;

  res_t  run_q[$];           // results of the item being decoded
  res_t  utf8_expect_q[$];   // results still owed by the block
  stim_t stim_q[$];

  logic  row_typed;
  res_t  row_want;
  res_t  got_want;
  int    idle_pct;
  int    stall_pct;
  int    hold_reqs = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    mismatches = 0;
  int    stuck;

  escape_sequence_to_utf8_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- decoder model

  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void reset_parser();
    esc_mode   = MODE_IDLE;
    hex_left   = '0;
    oct_digits = '0;
    code_acc   = '0;
  endfunction

  function automatic void queue_res(logic [7:0] b, logic has, logic [2:0] err);
    res_t r;
    r.data = b;
    r.has  = has;
    r.err  = err;
    r.last = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void emit_utf8(logic [31:0] cp_in);
    logic [31:0] cp;
    cp = cp_in;
    if (cp > 32'h7fff_ffff) begin
      queue_res(8'h00, 1'b0, ERR_OVERFLOW);
    end else begin
      // surrogates and anything past the Unicode range become U+FFFD
      if ((cp >= 32'hd800 && cp <= 32'hdfff) || cp > 32'h10_ffff) cp = 32'hfffd;
      if (cp < 32'h80) begin
        queue_res(cp[7:0], 1'b1, ERR_NONE);
      end else if (cp < 32'h800) begin
        queue_res({3'b110, cp[10:6]}, 1'b1, ERR_NONE);
        queue_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
      end else if (cp < 32'h10000) begin
        queue_res({4'b1110, cp[15:12]}, 1'b1, ERR_NONE);
        queue_res({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
        queue_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
      end else begin
        queue_res({5'b11110, cp[20:18]}, 1'b1, ERR_NONE);
        queue_res({2'b10, cp[17:12]}, 1'b1, ERR_NONE);
        queue_res({2'b10, cp[11:6]}, 1'b1, ERR_NONE);
        queue_res({2'b10, cp[5:0]}, 1'b1, ERR_NONE);
      end
    end
  endfunction

  function automatic void pass_or_escape(logic [7:0] b);
    if (b == CH_BACKSLASH) begin
      reset_parser();
      esc_mode = MODE_ESC;
    end else begin
      queue_res(b, 1'b1, ERR_NONE);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eom);
    int          d;
    logic [31:0] cp;
    res_t        r;
    run_q.delete();
    case (esc_mode)
      MODE_ESC: begin
        reset_parser();
        case (b)
          "a":          emit_utf8(32'h07);
          "b":          emit_utf8(32'h08);
          "f":          emit_utf8(32'h0c);
          "n":          emit_utf8(32'h0a);
          "r":          emit_utf8(32'h0d);
          "t":          emit_utf8(32'h09);
          "v":          emit_utf8(32'h0b);
          8'h22:        emit_utf8(32'h22);
          CH_BACKSLASH: emit_utf8(32'h5c);
          "x", "u", "U": begin
            esc_mode = MODE_HEX;
            hex_left = (b == "x") ? 4'd2 : (b == "u") ? 4'd4 : 4'd8;
          end
          default: begin
            if (b inside {["0":"7"]}) begin
              esc_mode   = MODE_OCT;
              oct_digits = 2'd1;
              code_acc   = {29'd0, b[2:0]};
            end else begin
              queue_res(8'h00, 1'b0, ERR_BAD_LETTER);
            end
          end
        endcase
      end
      MODE_HEX: begin
        d = hex_val(b);
        if (d < 0) begin
          reset_parser();
          queue_res(8'h00, 1'b0, ERR_BAD_HEX);
        end else begin
          code_acc = {code_acc[27:0], 4'(d)};
          hex_left = hex_left - 4'd1;
          if (hex_left == 4'd0) begin
            cp = code_acc;
            reset_parser();
            emit_utf8(cp);
          end
        end
      end
      MODE_OCT: begin
        if (b inside {["0":"7"]}) begin
          code_acc   = {code_acc[28:0], b[2:0]};
          oct_digits = oct_digits + 2'd1;
          if (oct_digits == 2'd3) begin
            cp = code_acc;
            reset_parser();
            emit_utf8(cp);
          end
        end else begin
          // octal ended by a foreign byte: flush, then treat the byte as fresh
          cp = code_acc;
          reset_parser();
          emit_utf8(cp);
          pass_or_escape(b);
        end
      end
      default: begin
        reset_parser();
        pass_or_escape(b);
      end
    endcase
    if (eom) begin
      if (esc_mode == MODE_OCT) begin
        cp = code_acc;
        reset_parser();
        emit_utf8(cp);
      end else if (esc_mode != MODE_IDLE) begin
        reset_parser();
        queue_res(8'h00, 1'b0, ERR_TRUNCATED);
      end
    end
    if (run_q.size() != 0) begin
      r = run_q.pop_back();
      r.last = 1'b1;
      run_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_stim(logic [7:0] b, logic eom);
    stim_t s;
    s.b   = b;
    s.eom = eom;
    stim_q.push_back(s);
  endfunction

  function automatic void mark_end();
    stim_t s;
    s = stim_q.pop_back();
    s.eom = 1'b1;
    stim_q.push_back(s);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "A" : "a";
    return (n < 4'd10) ? 8'("0" + n) : 8'(base + n - 4'd10);
  endfunction

  // backslash, kind letter, then the leading 'keep' of 'ndig' hex digits
  function automatic void queue_hex(logic [7:0] kind, int ndig, logic [31:0] val, int keep);
    push_stim(CH_BACKSLASH, 1'b0);
    push_stim(kind, 1'b0);
    for (int i = ndig - 1; i >= ndig - keep; i--) push_stim(hex_char(val[4*i +: 4]), 1'b0);
  endfunction

  function automatic void queue_fragment();
    int          sel;
    int          k;
    int          n;
    int          ndig;
    logic [7:0]  kind;
    logic [7:0]  b;
    logic [31:0] cp;
    sel  = $urandom_range(0, 99);
    k    = $urandom_range(0, 2);
    kind = (k == 0) ? "x" : (k == 1) ? "u" : "U";
    ndig = (k == 0) ? 2 : (k == 1) ? 4 : 8;
    if (sel < 25) begin
      do b = 8'($urandom); while (b == CH_BACKSLASH);
      push_stim(b, $urandom_range(0, 9) == 0);
    end else if (sel < 40) begin
      push_stim(CH_BACKSLASH, 1'b0);
      push_stim(ESC_LETTERS[$urandom_range(0, 8)], $urandom_range(0, 9) == 0);
    end else if (sel < 70) begin
      k = $urandom_range(0, 3);
      if (sel < 50) begin
        kind = "x";
        ndig = 2;
        cp   = $urandom_range(0, 255);
      end else if (sel < 60) begin
        kind = "u";
        ndig = 4;
        case (k)
          0:       cp = $urandom_range(0, 32'h7f);
          1:       cp = $urandom_range(32'h80, 32'h7ff);
          2:       cp = $urandom_range(32'h800, 32'hffff);
          default: cp = $urandom_range(32'hd800, 32'hdfff);
        endcase
      end else begin
        kind = "U";
        ndig = 8;
        case (k)
          0:       cp = $urandom_range(0, 32'hffff);
          1:       cp = $urandom_range(32'h1_0000, 32'h10_ffff);
          2:       cp = $urandom_range(32'h11_0000, 32'h7fff_ffff);
          default: cp = $urandom_range(32'h8000_0000, 32'hffff_ffff);
        endcase
      end
      queue_hex(kind, ndig, cp, ndig);
      if ($urandom_range(0, 9) == 0) mark_end();
    end else if (sel < 80) begin
      n = $urandom_range(1, 3);
      push_stim(CH_BACKSLASH, 1'b0);
      for (int i = 0; i < n; i++) push_stim(8'("0" + $urandom_range(0, 7)), 1'b0);
      k = $urandom_range(0, 2);
      if (k == 0) begin
        mark_end();
      end else if (k == 1 && n < 3) begin
        do b = 8'($urandom); while (b inside {["0":"7"], CH_BACKSLASH});
        push_stim(b, 1'b0);
      end
    end else if (sel < 85) begin
      do b = 8'($urandom);
      while (b inside {"a", "b", "f", "n", "r", "t", "v", 8'h22, CH_BACKSLASH,
                       "x", "u", "U", ["0":"7"]});
      push_stim(CH_BACKSLASH, 1'b0);
      push_stim(b, 1'b0);
    end else if (sel < 90) begin
      queue_hex(kind, ndig, $urandom, $urandom_range(0, ndig - 1));
      do b = 8'($urandom); while (hex_val(b) >= 0);
      push_stim(b, 1'b0);
    end else if (sel < 95) begin
      if ($urandom_range(0, 3) == 0) begin
        push_stim(CH_BACKSLASH, 1'b1);
      end else begin
        queue_hex(kind, ndig, $urandom, $urandom_range(0, ndig - 1));
        mark_end();
      end
    end else begin
      push_stim(8'($urandom), $urandom_range(0, 1));
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eom, input logic typed,
                           input res_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eom;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (utf8_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int send_gap, input int recv_stall);
    int    sent;
    stim_t s;
    idle_pct  = send_gap;
    stall_pct = recv_stall;
    sent      = 0;
    while (sent < n_items) begin
      queue_fragment();
      while (stim_q.size() != 0) begin
        s = stim_q.pop_front();
        send_item(s.b, s.eom, 1'b0, NONE_RES);
        sent++;
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen  <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst_n) begin
      // check first: nothing accepted at this edge can already be on the output
      if (out_tvalid && out_tready) begin
        if (utf8_expect_q.size() == 0) begin
          $error("unexpected result item: out_tdata=%04h out_tuser=%0b out_tlast=%0b",
                 out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          got_want = utf8_expect_q.pop_front();
          if (out_tdata[7:0] !== got_want.data) begin
            $error("out_byte: expected %02h, got %02h", got_want.data, out_tdata[7:0]);
            mismatches++;
          end
          if (out_tuser !== got_want.has) begin
            $error("has_byte: expected %0b, got %0b", got_want.has, out_tuser);
            mismatches++;
          end
          if (out_tdata[10:8] !== got_want.err) begin
            $error("error_code: expected %0d, got %0d", got_want.err, out_tdata[10:8]);
            mismatches++;
          end
          if (out_tlast !== got_want.last) begin
            $error("last_of_run: expected %0b, got %0b", got_want.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        if (row_typed) begin
          run_q.delete();
          run_q.push_back(row_want);
        end
        foreach (run_q[i]) utf8_expect_q.push_back(run_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    row_typed = 1'b0;
    row_want  = NONE_RES;
    idle_pct  = 0;
    stall_pct = 0;
    reset_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].b, DIR_ROWS[i].eom, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    wait_drained();

    run_phase(20, 0, 0);
    run_phase(20, 86, 0);
    run_phase(20, 0, 86);
    run_phase(20, 24, 24);

    // long output hold-off while the sender keeps pushing: queue fills, input stalls
    @(posedge clk);
    hold_reqs++;
    run_phase(16, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
